>>> rtl/text_grid_renderer_macros.svh
// Assertion macros used by the checker of the text grid renderer.
// Each macro expands to one labelled concurrent assertion with an active-low
// reset that disables it.
`ifndef TEXT_GRID_RENDERER_MACROS_SVH
`define TEXT_GRID_RENDERER_MACROS_SVH

// Same-cycle implication.
`define TGR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tgr_pkg.sv
`timescale 1ns / 1ps

package tgr_pkg;

    // Field widths.
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIM_W    = 8;
    localparam int unsigned SCROLL_W = 16;
    localparam int unsigned LCOL_W   = 17;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Column arithmetic.
    localparam int unsigned TAB_STOP_DEFAULT = 8;
    localparam int unsigned MAX_RESULTS      = 8;
    localparam int unsigned CNT_W            = $clog2(MAX_RESULTS + 1);

    // Operation codes of an input beat.
    localparam logic [OPCODE_W-1:0] OP_CHAR      = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_END       = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_NEW_FRAME = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_UNUSED    = 2'd3;

    // Result kinds.
    localparam logic KIND_CELL       = 1'b0;
    localparam logic KIND_FRAME_DONE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_COLUMN = 2'd2;

    // Register reset values.
    localparam logic [DIM_W-1:0]    GRID_WIDTH_RESET    = 8'd80;
    localparam logic [DIM_W-1:0]    GRID_HEIGHT_RESET   = 8'd24;
    localparam logic [SCROLL_W-1:0] SCROLL_COLUMN_RESET = 16'd0;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_NONE    = 8'd0;

    // What the column unit reports back to the sequencer each cycle.
    typedef struct packed {
        logic [LCOL_W-1:0] lcol;      // logical column after the advance
        logic [DIM_W-1:0]  scol;      // screen column plus one
        logic              at_edge;   // screen column plus one reaches the width
        logic              room;      // screen column is still inside the grid
        logic              last_row;  // current row is the last of the grid
    } t_col_step;

endpackage

>>> rtl/tgr_col_unit.sv
`timescale 1ns / 1ps

module tgr_col_unit #(
    parameter int unsigned TAB_STOP = tgr_pkg::TAB_STOP_DEFAULT
) (
    input  logic [tgr_pkg::LCOL_W-1:0]     i_lcol,
    input  logic [$clog2(TAB_STOP)-1:0]    i_tab_pos,
    input  logic                           i_tab_jump,
    input  logic [tgr_pkg::DIM_W-1:0]      i_scol,
    input  logic [tgr_pkg::DIM_W-1:0]      i_row,
    input  logic [tgr_pkg::DIM_W-1:0]      i_grid_width,
    input  logic [tgr_pkg::DIM_W-1:0]      i_grid_height,
    output tgr_pkg::t_col_step             o_step,
    output logic [$clog2(TAB_STOP)-1:0]    o_tab_pos,
    output logic [$clog2(TAB_STOP+1)-1:0]  o_tab_len
);

    localparam int unsigned PW = $clog2(TAB_STOP);
    localparam int unsigned KW = $clog2(TAB_STOP + 1);
    localparam int unsigned LW = tgr_pkg::LCOL_W;
    localparam int unsigned DW = tgr_pkg::DIM_W;

    logic [KW-1:0]   w_step;
    logic [LW:0]     w_sum;
    logic [DW:0]     w_scol_inc;

    // Distance to the next tab stop, from the running position within the stop.
    assign o_tab_len = KW'(TAB_STOP) - KW'(i_tab_pos);
    assign w_step    = i_tab_jump ? o_tab_len : KW'(1);
    assign w_sum     = {1'b0, i_lcol} + (LW + 1)'(w_step);

    assign o_step.lcol = w_sum[LW] ? {LW{1'b1}} : w_sum[LW-1:0];

    always_comb begin
        if (i_tab_jump || (i_tab_pos == PW'(TAB_STOP - 1))) begin
            o_tab_pos = '0;
        end else begin
            o_tab_pos = i_tab_pos + PW'(1);
        end
    end

    assign w_scol_inc      = {1'b0, i_scol} + (DW + 1)'(1);
    assign o_step.scol     = w_scol_inc[DW-1:0];
    assign o_step.at_edge  = w_scol_inc >= {1'b0, i_grid_width};
    assign o_step.room     = i_scol < i_grid_width;
    assign o_step.last_row = ({1'b0, i_row} + (DW + 1)'(1)) >= {1'b0, i_grid_height};

endmodule

>>> rtl/text_grid_renderer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_opcode, i_ch, i_at_cursor
// result    out        o_out_valid / i_out_stall o_kind, o_grid_row, o_grid_col,
//                                                o_cell_char, o_last
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// An item is accepted and then takes one step of the sequencer in the common case.
// Entering the visible part of a row and clipping a row each add a step, a newline
// that ends a row adds the end-of-row step, end of buffer and a full grid add a step
// for the frame-done beat, and a tab adds a step per space it lays down plus one to close.
// The single column unit makes one column advance per cycle unless a result stall holds it.
// Reset is synchronous and active low; it loads the register defaults and clears the frame.
// A stalled result beat holds the sequencer only when it has a new beat to hand over.

module text_grid_renderer #(
    parameter int unsigned TAB_STOP = tgr_pkg::TAB_STOP_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [tgr_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [tgr_pkg::CHAR_W-1:0]       i_ch,
    input  logic                             i_at_cursor,
    // Result channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_kind,
    output logic [tgr_pkg::DIM_W-1:0]        o_grid_row,
    output logic [tgr_pkg::DIM_W-1:0]        o_grid_col,
    output logic [tgr_pkg::CHAR_W-1:0]       o_cell_char,
    output logic                             o_last,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tgr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned PW = $clog2(TAB_STOP);
    localparam int unsigned KW = $clog2(TAB_STOP + 1);
    localparam int unsigned DW = tgr_pkg::DIM_W;
    localparam int unsigned LW = tgr_pkg::LCOL_W;
    localparam int unsigned CW = tgr_pkg::CNT_W;
    localparam int unsigned SW = tgr_pkg::SCROLL_W;

    // Where the current row stands: still left of the scroll column, laying out
    // visible cells, throwing away a clipped tail, or the frame is complete.
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_VISIBLE,
        PH_DISCARD,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ENDROW,
        S_TAB,
        S_FINISH
    } t_state;

    // Control state.
    t_state                      r_state, n_state;
    t_phase                      r_phase, n_phase;
    logic [DW-1:0]               r_row, n_row;
    logic [DW-1:0]               r_scol, n_scol;
    logic [LW-1:0]               r_lcol, n_lcol;
    logic [PW-1:0]               r_tab_pos, n_tab_pos;
    logic [DW-1:0]               r_cur_row, n_cur_row;
    logic [DW-1:0]               r_cur_col, n_cur_col;
    logic                        r_out_valid, n_out_valid;

    // Configuration registers.
    logic [DW-1:0]               r_grid_width, n_grid_width;
    logic [DW-1:0]               r_grid_height, n_grid_height;
    logic [SW-1:0]               r_scroll_col, n_scroll_col;

    // Payload of the item in work and of the waiting result beat.
    logic [tgr_pkg::OPCODE_W-1:0] r_op, n_op;
    logic [tgr_pkg::CHAR_W-1:0]   r_ch, n_ch;
    logic                         r_at_cur, n_at_cur;
    logic [KW-1:0]                r_tab_left, n_tab_left;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic                         r_out_kind, n_out_kind;
    logic [DW-1:0]                r_out_row, n_out_row;
    logic [DW-1:0]                r_out_col, n_out_col;
    logic [tgr_pkg::CHAR_W-1:0]   r_out_char, n_out_char;
    logic                         r_out_last, n_out_last;

    tgr_pkg::t_col_step          w_step;
    logic [PW-1:0]               w_tab_pos;
    logic [KW-1:0]               w_tab_len;
    logic                        w_tab_jump;
    logic                        w_out_free;
    logic                        w_in_accept;

    // In the skip part of a row a tab jumps straight to the next stop; everywhere
    // else the logical column moves on by one.
    assign w_tab_jump = (r_state == S_EXEC) && (r_phase == PH_SKIP)
                        && (r_ch == tgr_pkg::CH_TAB);

    tgr_col_unit #(
        .TAB_STOP      (TAB_STOP)
    ) u_col_unit (
        .i_lcol        (r_lcol),
        .i_tab_pos     (r_tab_pos),
        .i_tab_jump    (w_tab_jump),
        .i_scol        (r_scol),
        .i_row         (r_row),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .o_step        (w_step),
        .o_tab_pos     (w_tab_pos),
        .o_tab_len     (w_tab_len)
    );

    // The result register can take a new beat when it is empty or being drained.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_row         = r_row;
        n_scol        = r_scol;
        n_lcol        = r_lcol;
        n_tab_pos     = r_tab_pos;
        n_cur_row     = r_cur_row;
        n_cur_col     = r_cur_col;
        n_op          = r_op;
        n_ch          = r_ch;
        n_at_cur      = r_at_cur;
        n_tab_left    = r_tab_left;
        n_cnt         = r_cnt;
        n_out_valid   = w_out_free ? 1'b0 : r_out_valid;
        n_out_kind    = r_out_kind;
        n_out_row     = r_out_row;
        n_out_col     = r_out_col;
        n_out_char    = r_out_char;
        n_out_last    = r_out_last;
        n_grid_width  = r_grid_width;
        n_grid_height = r_grid_height;
        n_scroll_col  = r_scroll_col;

        if (i_cfg_we) begin
            case (i_cfg_index)
                tgr_pkg::CFG_GRID_WIDTH:    n_grid_width  = i_cfg_data[DW-1:0];
                tgr_pkg::CFG_GRID_HEIGHT:   n_grid_height = i_cfg_data[DW-1:0];
                tgr_pkg::CFG_SCROLL_COLUMN: n_scroll_col  = i_cfg_data[SW-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_op     = i_opcode;
                    n_ch     = i_ch;
                    n_at_cur = i_at_cursor;
                    n_state  = S_EXEC;
                end
            end

            S_EXEC: begin
                if (r_op == tgr_pkg::OP_NEW_FRAME) begin
                    n_row     = '0;
                    n_scol    = '0;
                    n_lcol    = '0;
                    n_tab_pos = '0;
                    n_phase   = PH_SKIP;
                    n_cur_row = '0;
                    n_cur_col = '0;
                    n_state   = S_IDLE;
                end else if ((r_op == tgr_pkg::OP_UNUSED) || (r_phase == PH_DONE)) begin
                    n_state = S_IDLE;
                end else if (r_op == tgr_pkg::OP_END) begin
                    // End of buffer: a cursor sitting after a clipped row that is not
                    // the last one lands at the start of the next row.
                    if (r_phase == PH_DISCARD) begin
                        if (r_at_cur && !w_step.last_row && (r_grid_width != '0)) begin
                            n_cur_row = r_row + DW'(1);
                            n_cur_col = '0;
                        end
                    end else if (r_at_cur && w_step.room) begin
                        n_cur_row = r_row;
                        n_cur_col = r_scol;
                    end
                    n_state = S_FINISH;
                end else begin
                    case (r_phase)
                        PH_SKIP: begin
                            if (({1'b0, r_scroll_col} <= r_lcol) || (r_ch == tgr_pkg::CH_NEWLINE)) begin
                                // Take the same character again as a visible one.
                                n_phase = PH_VISIBLE;
                            end else begin
                                n_lcol    = w_step.lcol;
                                n_tab_pos = w_tab_pos;
                                n_state   = S_IDLE;
                            end
                        end

                        PH_VISIBLE: begin
                            if (!w_step.room) begin
                                n_phase = PH_DISCARD;
                            end else if (r_ch == tgr_pkg::CH_NEWLINE) begin
                                if (r_at_cur) begin
                                    n_cur_row = r_row;
                                    n_cur_col = r_scol;
                                end
                                n_state = S_ENDROW;
                            end else if (r_ch == tgr_pkg::CH_TAB) begin
                                if (r_at_cur) begin
                                    n_cur_row = r_row;
                                    n_cur_col = r_scol;
                                end
                                n_tab_left = w_tab_len;
                                n_cnt      = '0;
                                n_state    = S_TAB;
                            end else if (w_out_free) begin
                                if (r_at_cur) begin
                                    n_cur_row = r_row;
                                    n_cur_col = r_scol;
                                end
                                n_out_valid = 1'b1;
                                n_out_kind  = tgr_pkg::KIND_CELL;
                                n_out_row   = r_row;
                                n_out_col   = r_scol;
                                n_out_char  = r_ch;
                                n_out_last  = 1'b1;
                                n_scol      = w_step.scol;
                                n_lcol      = w_step.lcol;
                                n_tab_pos   = w_tab_pos;
                                if (w_step.at_edge) begin
                                    n_phase = PH_DISCARD;
                                end
                                n_state = S_IDLE;
                            end
                        end

                        default: begin
                            // Clipped tail: only the newline matters, unless the grid
                            // is already on its last row.
                            if (w_step.last_row) begin
                                n_state = S_FINISH;
                            end else if (r_ch == tgr_pkg::CH_NEWLINE) begin
                                n_state = S_ENDROW;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                    endcase
                end
            end

            S_ENDROW: begin
                if (w_step.last_row) begin
                    n_state = S_FINISH;
                end else begin
                    n_row     = r_row + DW'(1);
                    n_scol    = '0;
                    n_lcol    = '0;
                    n_tab_pos = '0;
                    n_phase   = PH_SKIP;
                    n_state   = S_IDLE;
                end
            end

            S_TAB: begin
                if ((r_tab_left != '0) && w_step.room) begin
                    // Spaces past the result limit still move the columns on.
                    if ((r_cnt >= CW'(tgr_pkg::MAX_RESULTS)) || w_out_free) begin
                        if (r_cnt < CW'(tgr_pkg::MAX_RESULTS)) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = tgr_pkg::KIND_CELL;
                            n_out_row   = r_row;
                            n_out_col   = r_scol;
                            n_out_char  = tgr_pkg::CH_SPACE;
                            n_out_last  = (r_tab_left == KW'(1)) || w_step.at_edge
                                          || (r_cnt == CW'(tgr_pkg::MAX_RESULTS - 1));
                            n_cnt       = r_cnt + CW'(1);
                        end
                        n_scol     = w_step.scol;
                        n_lcol     = w_step.lcol;
                        n_tab_pos  = w_tab_pos;
                        n_tab_left = r_tab_left - KW'(1);
                    end
                end else begin
                    if (!w_step.room) begin
                        n_phase = PH_DISCARD;
                    end
                    n_state = S_IDLE;
                end
            end

            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = tgr_pkg::KIND_FRAME_DONE;
                    n_out_row   = r_cur_row;
                    n_out_col   = r_cur_col;
                    n_out_char  = tgr_pkg::CH_NONE;
                    n_out_last  = 1'b1;
                    n_phase     = PH_DONE;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_SKIP;
            r_row         <= '0;
            r_scol        <= '0;
            r_lcol        <= '0;
            r_tab_pos     <= '0;
            r_cur_row     <= '0;
            r_cur_col     <= '0;
            r_out_valid   <= 1'b0;
            r_grid_width  <= tgr_pkg::GRID_WIDTH_RESET;
            r_grid_height <= tgr_pkg::GRID_HEIGHT_RESET;
            r_scroll_col  <= tgr_pkg::SCROLL_COLUMN_RESET;
        end else begin
            r_state       <= n_state;
            r_phase       <= n_phase;
            r_row         <= n_row;
            r_scol        <= n_scol;
            r_lcol        <= n_lcol;
            r_tab_pos     <= n_tab_pos;
            r_cur_row     <= n_cur_row;
            r_cur_col     <= n_cur_col;
            r_out_valid   <= n_out_valid;
            r_grid_width  <= n_grid_width;
            r_grid_height <= n_grid_height;
            r_scroll_col  <= n_scroll_col;
        end
        r_op       <= n_op;
        r_ch       <= n_ch;
        r_at_cur   <= n_at_cur;
        r_tab_left <= n_tab_left;
        r_cnt      <= n_cnt;
        r_out_kind <= n_out_kind;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_grid_row  = r_out_row;
    assign o_grid_col  = r_out_col;
    assign o_cell_char = r_out_char;
    assign o_last      = r_out_last;

endmodule

>>> rtl/tgr_checker.sv
`timescale 1ns / 1ps

`include "text_grid_renderer_macros.svh"

module tgr_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_stall,
    input  logic [tgr_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [tgr_pkg::CHAR_W-1:0]       i_ch,
    input  logic                             i_at_cursor,
    input  logic                             o_out_valid,
    input  logic                             i_out_stall,
    input  logic                             o_kind,
    input  logic [tgr_pkg::DIM_W-1:0]        o_grid_row,
    input  logic [tgr_pkg::DIM_W-1:0]        o_grid_col,
    input  logic [tgr_pkg::CHAR_W-1:0]       o_cell_char,
    input  logic                             o_last,
    input  logic                             i_cfg_we,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tgr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // A stalled result beat keeps its payload.
    `TGR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_kind) && $stable(o_grid_row) && $stable(o_grid_col)
        && $stable(o_cell_char) && $stable(o_last), "result beat changed while stalled")

    // A frame-done beat is always the final beat of its item and carries no character.
    `TGR_ASSERT_NOW(a_done_form, i_clk, i_rst_n, o_out_valid && (o_kind == tgr_pkg::KIND_FRAME_DONE),
        o_last && (o_cell_char == tgr_pkg::CH_NONE), "frame-done beat malformed")

    // Every accepted item leaves the block busy, with its input stalled, straight after it is taken.
    `TGR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall, "input taken again straight after a beat")

    // Leaving reset the result channel is empty.
    `TGR_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $rose(i_rst_n),
        !o_out_valid, "result beat present after reset")

endmodule

bind text_grid_renderer tgr_checker u_tgr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_opcode    (i_opcode),
    .i_ch        (i_ch),
    .i_at_cursor (i_at_cursor),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_kind      (o_kind),
    .o_grid_row  (o_grid_row),
    .o_grid_col  (o_grid_col),
    .o_cell_char (o_cell_char),
    .o_last      (o_last),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

>>> dv/text_grid_renderer_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the text grid renderer. Characters are laid into a
// grid by an in-bench layout predictor, and every result beat is compared with
// the oldest predicted beat. Directed tasks cover the corner cases first. A
// random task then runs many short frames under changing grid settings, with
// bursty input traffic and a stalling result receiver.

module text_grid_renderer_tb;
    import tgr_pkg::*;

    localparam int unsigned TAB_COLS      = TAB_STOP_DEFAULT;
    localparam int unsigned LCOL_CEILING  = (1 << LCOL_W) - 1;
    // A tab is the slowest item, since it lays down its spaces one at a time.
    // Waiting this long after the last result leaves the block idle.
    localparam int unsigned SETTLE_CYCLES = 32;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned RANDOM_ITEMS  = 200;
    localparam int unsigned REPORT_LIMIT  = 10;

    // Where the current row stands: left of the scroll column, on screen,
    // clipped, or the whole frame is finished.
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_VISIBLE,
        PH_DISCARD,
        PH_DONE
    } row_phase_e;

    typedef struct packed {
        logic              kind;
        logic [DIM_W-1:0]  row;
        logic [DIM_W-1:0]  col;
        logic [CHAR_W-1:0] chr;
        logic              last;
    } grid_beat_t;

    // Clock, reset and block ports. Every input starts at a known value.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [OPCODE_W-1:0]   in_opcode = OP_CHAR;
    logic [CHAR_W-1:0]     in_ch     = '0;
    logic                  in_cursor = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  out_kind;
    logic [DIM_W-1:0]      out_row;
    logic [DIM_W-1:0]      out_col;
    logic [CHAR_W-1:0]     out_char;
    logic                  out_last;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_GRID_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers and of the layout state.
    int unsigned grid_cols;
    int unsigned grid_rows;
    int unsigned scroll_col;
    int unsigned cur_row;
    int unsigned cur_scol;
    int unsigned cur_lcol;
    row_phase_e  cur_phase;
    int unsigned cursor_row;
    int unsigned cursor_col;

    grid_beat_t  beats_due[$];   // beats still owed by the block, oldest first
    grid_beat_t  item_beats[$];  // beats caused by the item being predicted
    int unsigned mismatches  = 0;
    int unsigned taken_items = 0;  // items that the block did not merely ignore
    int unsigned burst_left  = 0;
    int unsigned stall_hold  = 0;
    int unsigned quiet_cycles = 0;

    text_grid_renderer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_opcode    (in_opcode),
        .i_ch        (in_ch),
        .i_at_cursor (in_cursor),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_kind      (out_kind),
        .o_grid_row  (out_row),
        .o_grid_col  (out_col),
        .o_cell_char (out_char),
        .o_last      (out_last),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Layout predictor
    // ------------------------------------------------------------------

    function automatic void clear_frame();
        cur_row    = 0;
        cur_scol   = 0;
        cur_lcol   = 0;
        cur_phase  = PH_SKIP;
        cursor_row = 0;
        cursor_col = 0;
    endfunction

    // The block reports at most MAX_RESULTS beats per item; anything past
    // that would only be a blank cell, so it is simply not owed.
    function automatic void owe_beat(input logic kind, input int unsigned row,
                                     input int unsigned col, input int unsigned chr);
        grid_beat_t b;
        if (item_beats.size() >= MAX_RESULTS) begin
            return;
        end
        b.kind = kind;
        b.row  = row[DIM_W-1:0];
        b.col  = col[DIM_W-1:0];
        b.chr  = chr[CHAR_W-1:0];
        b.last = 1'b0;
        item_beats.push_back(b);
    endfunction

    function automatic void note_cursor(input int unsigned row, input int unsigned col);
        cursor_row = row & 8'hFF;
        cursor_col = col & 8'hFF;
    endfunction

    // The logical column saturates rather than wrapping.
    function automatic void bump_lcol(input int unsigned k);
        cur_lcol = (cur_lcol + k > LCOL_CEILING) ? LCOL_CEILING : cur_lcol + k;
    endfunction

    function automatic void close_frame();
        cur_phase = PH_DONE;
        owe_beat(KIND_FRAME_DONE, cursor_row, cursor_col, CH_NONE);
    endfunction

    // A newline on the last row completes the grid; otherwise the next row
    // starts from its left edge, back in the skipped part.
    function automatic void close_row();
        if (cur_row + 1 >= grid_rows) begin
            close_frame();
            return;
        end
        cur_row   = (cur_row + 1) & 8'hFF;
        cur_scol  = 0;
        cur_lcol  = 0;
        cur_phase = PH_SKIP;
    endfunction

    // Rest of a clipped row. On the last row the grid is already full, so the
    // next character of any kind closes the frame.
    function automatic void discard_char(input logic [CHAR_W-1:0] c);
        if (cur_row + 1 >= grid_rows) begin
            close_frame();
        end else if (c == CH_NEWLINE) begin
            close_row();
        end
    endfunction

    function automatic void visible_char(input logic [CHAR_W-1:0] c, input logic cur);
        int unsigned k;
        // A width lowered under a half-written row clips it at once.
        if (cur_scol >= grid_cols) begin
            cur_phase = PH_DISCARD;
            discard_char(c);
            return;
        end
        if (cur) begin
            note_cursor(cur_row, cur_scol);
        end
        if (c == CH_NEWLINE) begin
            close_row();
            return;
        end
        if (c == CH_TAB) begin
            k = TAB_COLS - (cur_lcol % TAB_COLS);
            while (k != 0 && cur_scol < grid_cols) begin
                owe_beat(KIND_CELL, cur_row, cur_scol, CH_SPACE);
                cur_scol++;
                bump_lcol(1);
                k--;
            end
        end else begin
            owe_beat(KIND_CELL, cur_row, cur_scol, c);
            cur_scol++;
            bump_lcol(1);
        end
        if (cur_scol >= grid_cols) begin
            cur_phase = PH_DISCARD;
        end
    endfunction

    // Left of the scroll column characters only move the logical column. A
    // tab may carry it past the left edge, and a newline still ends the row.
    function automatic void skip_char(input logic [CHAR_W-1:0] c, input logic cur);
        if (cur_lcol >= scroll_col || c == CH_NEWLINE) begin
            cur_phase = PH_VISIBLE;
            visible_char(c, cur);
        end else if (c == CH_TAB) begin
            bump_lcol(TAB_COLS - (cur_lcol % TAB_COLS));
        end else begin
            bump_lcol(1);
        end
    endfunction

    // Works out the beats one accepted item causes and queues them. Returns
    // whether the block does anything with the item at all.
    function automatic bit layout_item(input logic [OPCODE_W-1:0] op,
                                       input logic [CHAR_W-1:0] c, input logic cur);
        item_beats.delete();
        if (op == OP_NEW_FRAME) begin
            clear_frame();
            return 1'b1;
        end
        if (op == OP_UNUSED || cur_phase == PH_DONE) begin
            return 1'b0;
        end
        if (op == OP_CHAR) begin
            case (cur_phase)
                PH_SKIP:    skip_char(c, cur);
                PH_VISIBLE: visible_char(c, cur);
                default:    discard_char(c);
            endcase
        end else begin
            // End of buffer. Inside a clipped row the cursor belongs to the
            // start of the row below, if there is one.
            if (cur_phase == PH_DISCARD) begin
                if (cur && cur_row + 1 < grid_rows && grid_cols > 0) begin
                    note_cursor(cur_row + 1, 0);
                end
            end else if (cur && cur_scol < grid_cols) begin
                note_cursor(cur_row, cur_scol);
            end
            close_frame();
        end
        if (item_beats.size() != 0) begin
            item_beats[item_beats.size() - 1].last = 1'b1;
        end
        foreach (item_beats[i]) begin
            beats_due.push_back(item_beats[i]);
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers and checking
    // ------------------------------------------------------------------

    function automatic string beat_text(input grid_beat_t b);
        return $sformatf("kind=%0d row=%0d col=%0d char=%0d last=%0d",
                         b.kind, b.row, b.col, b.chr, b.last);
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endfunction

    // Sends one input beat and predicts its effect once it is taken. The
    // sender works in bursts; between bursts valid drops for a random gap,
    // and some bursts follow on with no gap at all.
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] c,
                             input logic cur);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_ch     <= c;
        in_cursor <= cur;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        if (layout_item(op, c, cur)) begin
            taken_items++;
        end
    endtask

    // Stops input and lets the block run dry: every owed beat has arrived,
    // and any item that causes no beat has had time to finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (beats_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers on back-to-back cycles. The 8-bit registers
    // get random upper data bits, which they must ignore.
    task automatic set_grid(input int unsigned cols, input int unsigned rows,
                            input int unsigned scroll);
        logic [7:0] junk;
        junk = $urandom_range(0, 255);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_data  <= {junk, cols[7:0]};
        @(posedge clk);
        junk = $urandom_range(0, 255);
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_data  <= {junk, rows[7:0]};
        @(posedge clk);
        cfg_index <= CFG_SCROLL_COLUMN;
        cfg_data  <= scroll[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        grid_cols  = cols & 8'hFF;
        grid_rows  = rows & 8'hFF;
        scroll_col = scroll & 16'hFFFF;
    endtask

    // Result receiver: runs of free cycles alternate with short stalls, so
    // stalls land on every part of the block's work.
    always @(posedge clk) begin
        if (stall_hold == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                stall_hold = $urandom_range(1, 6);
            end else begin
                out_stall <= 1'b0;
                stall_hold = $urandom_range(1, 24);
            end
        end else begin
            stall_hold--;
        end
    end

    // Each result beat taken is matched against the oldest owed beat.
    always @(posedge clk) begin : check_results
        grid_beat_t got;
        grid_beat_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{out_kind, out_row, out_col, out_char, out_last};
            if (beats_due.size() == 0) begin
                report_mismatch({"unexpected beat ", beat_text(got)});
            end else begin
                want = beats_due.pop_front();
                if (got.kind !== want.kind || got.row !== want.row ||
                        got.col !== want.col || got.chr !== want.chr ||
                        got.last !== want.last) begin
                    report_mismatch({"expected ", beat_text(want), ", got ", beat_text(got)});
                end
            end
        end
    end

    // Watchdog: a hang shows up as a long run of cycles with no beat taken
    // on either channel.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values of the registers, every operation, tab fill, both extreme
    // byte values, a cursor noted on screen, and the ignored items.
    task automatic test_reset_grid_and_ops();
        send_item(OP_CHAR, "A", 1'b0);
        send_item(OP_CHAR, CH_TAB, 1'b0);
        send_item(OP_CHAR, 8'hFF, 1'b1);
        send_item(OP_CHAR, 8'h00, 1'b0);
        send_item(OP_UNUSED, 8'hFF, 1'b1);
        send_item(OP_CHAR, CH_NEWLINE, 1'b0);
        send_item(OP_END, 8'h00, 1'b0);
        // The frame is finished, so these two are dropped.
        send_item(OP_CHAR, "z", 1'b1);
        send_item(OP_END, 8'h00, 1'b1);
        send_item(OP_NEW_FRAME, 8'h00, 1'b0);
    endtask

    // Horizontal scroll with a tab overshooting the left edge, a tab clipped
    // at the right edge, a cursor inside the discarded rest that is never
    // noted, and a newline in the skipped part that fills the grid.
    task automatic test_scroll_and_clip();
        wait_idle();
        set_grid(4, 2, 3);
        send_item(OP_CHAR, "a", 1'b0);
        send_item(OP_CHAR, CH_TAB, 1'b0);
        send_item(OP_CHAR, "b", 1'b1);
        send_item(OP_CHAR, CH_TAB, 1'b0);
        send_item(OP_CHAR, "c", 1'b1);
        send_item(OP_CHAR, CH_NEWLINE, 1'b0);
        send_item(OP_CHAR, CH_NEWLINE, 1'b0);
        send_item(OP_NEW_FRAME, 8'h00, 1'b0);
    endtask

    // Smallest grid filled by clipping, so the frame closes on the following
    // character; then end of buffer in a clipped row above the last one.
    task automatic test_clipped_rows();
        wait_idle();
        set_grid(1, 1, 0);
        send_item(OP_CHAR, "x", 1'b0);
        send_item(OP_CHAR, "y", 1'b1);
        send_item(OP_NEW_FRAME, 8'h00, 1'b0);
        wait_idle();
        set_grid(2, 3, 0);
        send_item(OP_CHAR, "p", 1'b0);
        send_item(OP_CHAR, "q", 1'b0);
        send_item(OP_END, 8'h00, 1'b1);
        send_item(OP_NEW_FRAME, 8'h00, 1'b0);
    endtask

    // Width and height lowered under a frame in progress.
    task automatic test_resize_mid_frame();
        wait_idle();
        set_grid(8, 4, 0);
        send_item(OP_CHAR, "a", 1'b0);
        send_item(OP_CHAR, "b", 1'b0);
        send_item(OP_CHAR, "c", 1'b0);
        wait_idle();
        set_grid(2, 4, 0);
        send_item(OP_CHAR, "d", 1'b0);
        send_item(OP_CHAR, CH_NEWLINE, 1'b0);
        send_item(OP_CHAR, CH_NEWLINE, 1'b0);
        wait_idle();
        set_grid(2, 2, 0);
        send_item(OP_CHAR, CH_NEWLINE, 1'b0);
        send_item(OP_NEW_FRAME, 8'h00, 1'b0);
    endtask

    // Largest grid and scroll: nothing reaches the screen, but rows still end.
    task automatic test_largest_settings();
        wait_idle();
        set_grid(255, 255, 65535);
        send_item(OP_CHAR, "a", 1'b0);
        send_item(OP_CHAR, CH_TAB, 1'b1);
        send_item(OP_CHAR, CH_NEWLINE, 1'b0);
        send_item(OP_END, 8'h00, 1'b1);
        send_item(OP_NEW_FRAME, 8'h00, 1'b0);
    endtask

    // Many short frames, each under fresh grid settings. Most of each frame
    // is text with tabs and newlines; stray ends, restarts, unused opcodes
    // and arbitrary bytes are mixed in as noise.
    task automatic test_random_frames();
        int unsigned base;
        int unsigned cols;
        int unsigned rows;
        int unsigned scroll;
        int unsigned pick;
        int unsigned len;
        logic [OPCODE_W-1:0] op;
        logic [CHAR_W-1:0]   c;
        base = taken_items;
        while (taken_items - base < RANDOM_ITEMS) begin
            wait_idle();
            pick = $urandom_range(0, 7);
            cols = (pick == 0) ? 1 : (pick == 1) ? 255 : $urandom_range(2, 20);
            pick = $urandom_range(0, 7);
            rows = (pick == 0) ? 1 : (pick == 1) ? 255 : $urandom_range(2, 6);
            pick = $urandom_range(0, 7);
            if (pick < 4) begin
                scroll = 0;
            end else if (pick < 6) begin
                scroll = $urandom_range(1, 12);
            end else if (pick == 6) begin
                scroll = $urandom_range(13, 40);
            end else begin
                scroll = 65535;
            end
            set_grid(cols, rows, scroll);
            send_item(OP_NEW_FRAME, $urandom_range(0, 255), $urandom_range(0, 1));
            len = $urandom_range(4, 40);
            repeat (len) begin
                pick = $urandom_range(0, 99);
                op   = OP_CHAR;
                c    = $urandom_range(32, 126);
                if (pick < 12) begin
                    c = CH_TAB;
                end else if (pick < 26) begin
                    c = CH_NEWLINE;
                end else if (pick < 32) begin
                    c = $urandom_range(0, 255);
                end else if (pick < 36) begin
                    op = OP_END;
                end else if (pick < 38) begin
                    op = OP_NEW_FRAME;
                end else if (pick < 40) begin
                    op = OP_UNUSED;
                    c  = $urandom_range(0, 255);
                end
                send_item(op, c, $urandom_range(0, 5) == 0);
            end
            send_item(OP_END, $urandom_range(0, 255), $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        grid_cols  = GRID_WIDTH_RESET;
        grid_rows  = GRID_HEIGHT_RESET;
        scroll_col = SCROLL_COLUMN_RESET;
        clear_frame();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_grid_and_ops();
        test_scroll_and_clip();
        test_clipped_rows();
        test_resize_mid_frame();
        test_largest_settings();
        test_random_frames();

        wait_idle();
        if (beats_due.size() != 0) begin
            report_mismatch($sformatf("%0d beats never arrived", beats_due.size()));
        end
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
